[sv/poi_pkg.sv]
// poi_pkg: shared widths, constants, microcode types and control store for the
// planar odometry integrator
// no dependencies; imported by poi_seq, planar_odometry_integrator and its bench
package poi_pkg;

    // field widths
    localparam int SPEED_W = 16;
    localparam int DT_W    = 16;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_DEPTH   = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
    localparam int ITER_W       = $clog2(ATAN_DEPTH);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);
    localparam int ANG_W = 32;
    localparam int CS_W  = 33;
    localparam logic signed [CS_W-1:0] GAIN_Q30 = CS_W'(652032874);

    // shared multiplier and accumulator
    localparam int MA_W   = 33;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;
    localparam int PART_W = 33;
    localparam int LO_W   = 16;
    localparam int ACC_W  = 68;
    localparam logic signed [MA_W-1:0] RAD_TO_BAM = MA_W'(683565276);
    localparam int POS_SHIFT  = 42;
    localparam int HEAD_SHIFT = 44;
    localparam logic signed [ACC_W-1:0] POS_BIAS  = ACC_W'(64'd1 << (POS_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] HEAD_BIAS = ACC_W'(64'd1 << (HEAD_SHIFT - 1));
    localparam int STEP_W = ACC_W - POS_SHIFT;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_WAIT_IN,
        OP_CORDIC_ITER,
        OP_QROT,
        OP_BIAS_HEAD,
        OP_BIAS_POS,
        OP_UPD_X,
        OP_UPD_Y,
        OP_UPD_H,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        A_COS,
        A_SIN,
        A_FWD,
        A_LAT,
        A_YAW,
        A_RAD
    } a_sel_t;

    typedef enum logic [2:0] {
        B_DT,
        B_FD_HI,
        B_FD_LO,
        B_LD_HI,
        B_LD_LO,
        B_YD_HI,
        B_YD_LO
    } b_sel_t;

    typedef enum logic [2:0] {
        P_NONE,
        P_FD,
        P_LD,
        P_YD,
        P_ADD,
        P_ADD_SH,
        P_SUB,
        P_SUB_SH
    } p_op_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_HOLD_IN,
        J_LOOP,
        J_HOLD_OUT
    } jmp_t;

    localparam int PROG_LEN = 23;
    localparam int PC_W     = $clog2(PROG_LEN);
    localparam logic [PC_W-1:0] STEP_WAIT = '0;

    typedef struct packed {
        op_t              op;
        a_sel_t           a_sel;
        b_sel_t           b_sel;
        p_op_t            p_op;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } ctl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic iter_last;
    } seq_status_t;

    // control store: the product of one step is used by the p_op of the next
    localparam ctl_word_t PROGRAM [PROG_LEN] = '{
        '{OP_WAIT_IN,     A_FWD, B_DT,    P_NONE,   J_HOLD_IN,  STEP_WAIT},
        '{OP_NONE,        A_FWD, B_DT,    P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_LAT, B_DT,    P_FD,     J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_YAW, B_DT,    P_LD,     J_NEXT,     STEP_WAIT},
        '{OP_BIAS_HEAD,   A_RAD, B_DT,    P_YD,     J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_RAD, B_YD_HI, P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_RAD, B_YD_LO, P_ADD_SH, J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_RAD, B_DT,    P_ADD,    J_NEXT,     STEP_WAIT},
        '{OP_UPD_H,       A_RAD, B_DT,    P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_CORDIC_ITER, A_RAD, B_DT,    P_NONE,   J_LOOP,     STEP_WAIT},
        '{OP_QROT,        A_RAD, B_DT,    P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_BIAS_POS,    A_COS, B_FD_HI, P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_COS, B_FD_LO, P_ADD_SH, J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_SIN, B_LD_HI, P_ADD,    J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_SIN, B_LD_LO, P_SUB_SH, J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_SIN, B_DT,    P_SUB,    J_NEXT,     STEP_WAIT},
        '{OP_UPD_X,       A_SIN, B_FD_HI, P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_SIN, B_FD_LO, P_ADD_SH, J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_COS, B_LD_HI, P_ADD,    J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_COS, B_LD_LO, P_ADD_SH, J_NEXT,     STEP_WAIT},
        '{OP_NONE,        A_COS, B_DT,    P_ADD,    J_NEXT,     STEP_WAIT},
        '{OP_UPD_Y,       A_COS, B_DT,    P_NONE,   J_NEXT,     STEP_WAIT},
        '{OP_OUT,         A_COS, B_DT,    P_NONE,   J_HOLD_OUT, STEP_WAIT}
    };

    // arctangent of 2^-i, full turn = 2^32
    function automatic logic [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic [ANG_W-1:0] v;
        begin
            v = '0;
            unique case (idx)
                5'd0:    v = 32'd536870912;
                5'd1:    v = 32'd316933406;
                5'd2:    v = 32'd167458907;
                5'd3:    v = 32'd85004756;
                5'd4:    v = 32'd42667331;
                5'd5:    v = 32'd21354465;
                5'd6:    v = 32'd10679838;
                5'd7:    v = 32'd5340245;
                5'd8:    v = 32'd2670163;
                5'd9:    v = 32'd1335087;
                5'd10:   v = 32'd667544;
                5'd11:   v = 32'd333772;
                5'd12:   v = 32'd166886;
                5'd13:   v = 32'd83443;
                5'd14:   v = 32'd41722;
                5'd15:   v = 32'd20861;
                5'd16:   v = 32'd10430;
                5'd17:   v = 32'd5215;
                5'd18:   v = 32'd2608;
                5'd19:   v = 32'd1304;
                5'd20:   v = 32'd652;
                5'd21:   v = 32'd326;
                5'd22:   v = 32'd163;
                5'd23:   v = 32'd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[sv/poi_seq.sv]
// poi_seq: microcode sequencer, step counter and control store read-out
// depends on poi_pkg
module poi_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  poi_pkg::seq_status_t status,
    output poi_pkg::ctl_word_t   ctl
);
    import poi_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    assign ctl = PROGRAM[pc_reg];

    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctl.jmp)
            J_NEXT:
            begin
                pc_next = pc_reg + PC_W'(1);
            end
            J_HOLD_IN:
            begin
                if (status.in_valid)
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
            end
            J_LOOP:
            begin
                if (status.iter_last)
                begin
                    pc_next = pc_reg + PC_W'(1);
                end
            end
            J_HOLD_OUT:
            begin
                if (status.out_free)
                begin
                    pc_next = ctl.target;
                end
            end
            default:
            begin
                pc_next = STEP_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[sv/planar_odometry_integrator.sv]
// planar_odometry_integrator: fixed-point planar dead-reckoning odometry with a
// microcoded datapath (iterative cordic, one shared multiplier, accumulator)
// depends on poi_pkg and poi_seq
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | forward_speed, lateral_speed, yaw_rate, time_step
//  m_*     | out | m_tvalid/m_tready  | pos_x, pos_y, heading
//
// from its acceptance to its result being loaded, one item runs through the cordic loop
// (one iteration per cycle) and the single multiplier (one product per step); then the
// sequencer returns to its wait step for the next transaction
// reset clears the pose (x, y, heading) and the step counter
// a new transaction is taken while the previous result still sits in the output register;
// the sequencer holds at its first step for input and at its last step until out_free
module planar_odometry_integrator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] forward_speed, [31:16] lateral_speed, [47:32] yaw_rate, [63:48] time_step
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] pos_x, [63:32] pos_y, [79:64] heading
    output logic [79:0] m_tdata
);
    import poi_pkg::*;

    ctl_word_t   ctl;
    seq_status_t status;

    // pose state
    logic signed [POS_W-1:0]  x_reg, x_next;
    logic signed [POS_W-1:0]  y_reg, y_next;
    logic        [HEAD_W-1:0] h_reg, h_next;

    // latched transaction
    logic signed [SPEED_W-1:0] fwd_reg, lat_reg, yaw_reg;
    logic        [DT_W-1:0]    dt_reg;

    // cordic: cx/cy end up holding cos/sin of the old heading
    logic signed [CS_W-1:0]   cx_reg, cx_next;
    logic signed [CS_W-1:0]   cy_reg, cy_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    quad_t                    quad_reg, quad_next;
    logic        [ITER_W-1:0] iter_reg, iter_next;

    // speed * time step partial results
    logic signed [PART_W-1:0] fd_reg, fd_next;
    logic signed [PART_W-1:0] ld_reg, ld_next;
    logic signed [PART_W-1:0] yd_reg, yd_next;

    // shared multiplier and accumulator
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [79:0] out_data_reg, out_data_next;

    logic accept;
    logic out_free;

    // cordic helpers
    logic        [HEAD_W-1:0]  h_round;
    quad_t                     quad_init;
    logic        [HEAD_W-1:0]  resid;
    logic signed [CS_W-1:0]    xs, ys;
    logic signed [ANG_W-1:0]   at;

    // position update helpers
    logic signed [STEP_W-1:0]  pos_step;
    logic signed [POS_W:0]     pos_sum_x, pos_sum_y;
    logic signed [POS_W-1:0]   x_sat, y_sat;

    assign s_tready = (ctl.op == OP_WAIT_IN);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.in_valid  = s_tvalid;
    assign status.out_free  = out_free;
    assign status.iter_last = (iter_reg == ITER_LAST);

    poi_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    // quarter-turn reduction: nearest multiple of 90 degrees, residual in [-45, 45)
    assign h_round   = h_reg + 16'h2000;
    assign quad_init = quad_t'(h_round[HEAD_W-1:HEAD_W-2]);
    assign resid     = h_reg - {h_round[HEAD_W-1:HEAD_W-2], {(HEAD_W-2){1'b0}}};

    assign xs = cx_reg >>> iter_reg;
    assign ys = cy_reg >>> iter_reg;
    assign at = signed'(atan_entry(iter_reg));

    // rounded step (bias already in the accumulator), then saturating add
    assign pos_step  = acc_reg[ACC_W-1:POS_SHIFT];
    assign pos_sum_x = (POS_W+1)'(x_reg) + (POS_W+1)'(pos_step);
    assign pos_sum_y = (POS_W+1)'(y_reg) + (POS_W+1)'(pos_step);

    always_comb
    begin
        x_sat = pos_sum_x[POS_W-1:0];
        if (pos_sum_x[POS_W] != pos_sum_x[POS_W-1])
        begin
            x_sat = pos_sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        y_sat = pos_sum_y[POS_W-1:0];
        if (pos_sum_y[POS_W] != pos_sum_y[POS_W-1])
        begin
            y_sat = pos_sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    // multiplier operand selection
    always_comb
    begin
        case (ctl.a_sel)
            A_COS:   mul_a = cx_reg;
            A_SIN:   mul_a = cy_reg;
            A_FWD:   mul_a = MA_W'(fwd_reg);
            A_LAT:   mul_a = MA_W'(lat_reg);
            A_YAW:   mul_a = MA_W'(yaw_reg);
            A_RAD:   mul_a = RAD_TO_BAM;
            default: mul_a = '0;
        endcase
        case (ctl.b_sel)
            B_DT:    mul_b = {1'b0, dt_reg};
            B_FD_HI: mul_b = fd_reg[PART_W-1:LO_W];
            B_FD_LO: mul_b = {1'b0, fd_reg[LO_W-1:0]};
            B_LD_HI: mul_b = ld_reg[PART_W-1:LO_W];
            B_LD_LO: mul_b = {1'b0, ld_reg[LO_W-1:0]};
            B_YD_HI: mul_b = yd_reg[PART_W-1:LO_W];
            B_YD_LO: mul_b = {1'b0, yd_reg[LO_W-1:0]};
            default: mul_b = '0;
        endcase
        prod_next = mul_a * mul_b;
    end

    // datapath next values
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        h_next         = h_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        z_next         = z_reg;
        quad_next      = quad_reg;
        iter_next      = iter_reg;
        fd_next        = fd_reg;
        ld_next        = ld_reg;
        yd_next        = yd_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        // product of the previous step
        case (ctl.p_op)
            P_FD:     fd_next  = prod_reg[PART_W-1:0];
            P_LD:     ld_next  = prod_reg[PART_W-1:0];
            P_YD:     yd_next  = prod_reg[PART_W-1:0];
            P_ADD:    acc_next = acc_reg + ACC_W'(prod_reg);
            P_ADD_SH: acc_next = acc_reg + (ACC_W'(prod_reg) <<< LO_W);
            P_SUB:    acc_next = acc_reg - ACC_W'(prod_reg);
            P_SUB_SH: acc_next = acc_reg - (ACC_W'(prod_reg) <<< LO_W);
            default:  ;
        endcase

        unique case (ctl.op)
            OP_WAIT_IN:
            begin
                if (accept)
                begin
                    cx_next   = GAIN_Q30;
                    cy_next   = '0;
                    z_next    = {resid, {(ANG_W-HEAD_W){1'b0}}};
                    quad_next = quad_init;
                    iter_next = '0;
                end
            end
            OP_CORDIC_ITER:
            begin
                if (!z_reg[ANG_W-1])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next  = z_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next  = z_reg + at;
                end
                iter_next = iter_reg + ITER_W'(1);
            end
            OP_QROT:
            begin
                unique case (quad_reg)
                    QUAD_90:
                    begin
                        cx_next = -cy_reg;
                        cy_next = cx_reg;
                    end
                    QUAD_180:
                    begin
                        cx_next = -cx_reg;
                        cy_next = -cy_reg;
                    end
                    QUAD_270:
                    begin
                        cx_next = cy_reg;
                        cy_next = -cx_reg;
                    end
                    default: ;
                endcase
            end
            OP_BIAS_HEAD:
            begin
                acc_next = HEAD_BIAS;
            end
            OP_BIAS_POS:
            begin
                acc_next = POS_BIAS;
            end
            OP_UPD_X:
            begin
                x_next   = x_sat;
                acc_next = POS_BIAS;
            end
            OP_UPD_Y:
            begin
                y_next = y_sat;
            end
            OP_UPD_H:
            begin
                h_next = h_reg + acc_reg[HEAD_SHIFT+HEAD_W-1:HEAD_SHIFT];
            end
            OP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {h_reg, y_reg, x_reg};
                end
            end
            default: ;
        endcase
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
            iter_reg      <= iter_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_reg <= s_tdata[15:0];
            lat_reg <= s_tdata[31:16];
            yaw_reg <= s_tdata[47:32];
            dt_reg  <= s_tdata[63:48];
        end
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        z_reg        <= z_next;
        quad_reg     <= quad_next;
        fd_reg       <= fd_next;
        ld_reg       <= ld_next;
        yd_reg       <= yd_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule

[bench/planar_odometry_integrator_tb.sv]
// planar_odometry_integrator_tb: self-checking bench for the planar odometry integrator
// drives motion transactions, predicts each pose update and compares every result
// depends on poi_pkg and planar_odometry_integrator
`timescale 1ns / 1ps

module planar_odometry_integrator_tb;
    import poi_pkg::*;

    // one motion transaction, first field in the lowest bits
    typedef struct packed {
        logic        [15:0] time_step;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] lateral_speed;
        logic signed [15:0] forward_speed;
    } motion_t;

    // one pose result, pos_x in the lowest bits
    typedef struct packed {
        logic        [15:0] heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } pose_t;

    localparam int     ROT_ITERS    = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam longint ROT_GAIN     = 652032874;    // cordic gain, q1.30
    localparam longint ANGLE_TO_BAM = 683565276;    // radians to binary angle, q16
    localparam int     RANDOM_ITEMS = 1900;
    localparam int     HOLD_OFF_AT  = 200;
    localparam int     HOLD_OFF_LEN = 400;
    localparam int     SETTLE       = 80;

    // arctangent of 2^-i, full turn = 2^32
    localparam longint ARCTAN_TURN32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [15:0] forward_speed, [31:16] lateral_speed, [47:32] yaw_rate, [63:48] time_step
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [31:0] pos_x, [63:32] pos_y, [79:64] heading
    logic [79:0] m_tdata;

    motion_t pending_motion [$];
    pose_t   expected_pose [$];
    int      motions_queued = 0;
    int      motions_taken = 0;
    int      fail_count = 0;
    bit      motion_taken = 1'b0;

    // predicted pose state
    logic signed [31:0] pose_x = '0;
    logic signed [31:0] pose_y = '0;
    logic        [15:0] pose_heading = '0;

    planar_odometry_integrator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // cosine and sine of a binary angle, q1.30
    function automatic void heading_sincos(input logic [15:0] h, output longint cos_q30,
                                           output longint sin_q30);
        logic [31:0] angle;
        logic [31:0] resid;
        quad_t       quad;
        longint      vx, vy, vz, sx, sy;
        begin
            angle = {h, 16'h0000};
            // nearest quarter turn, residual within an eighth of a turn
            quad  = quad_t'(2'((angle + 32'h2000_0000) >> 30));
            resid = angle - {quad, 30'd0};
            vz    = longint'($signed(resid));
            vx    = ROT_GAIN;
            vy    = 0;
            for (int i = 0; i < ROT_ITERS; i++)
            begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vz >= 0)
                begin
                    vx = vx - sy;
                    vy = vy + sx;
                    vz = vz - ARCTAN_TURN32[i];
                end
                else
                begin
                    vx = vx + sy;
                    vy = vy - sx;
                    vz = vz + ARCTAN_TURN32[i];
                end
            end
            case (quad)
                QUAD_0:
                begin
                    cos_q30 = vx;
                    sin_q30 = vy;
                end
                QUAD_90:
                begin
                    cos_q30 = -vy;
                    sin_q30 = vx;
                end
                QUAD_180:
                begin
                    cos_q30 = -vx;
                    sin_q30 = -vy;
                end
                default:
                begin
                    cos_q30 = vy;
                    sin_q30 = -vx;
                end
            endcase
        end
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                     input longint d);
        longint total;
        begin
            total = longint'(a) + d;
            if (total > 64'sd2147483647)
                return 32'sh7FFF_FFFF;
            if (total < -64'sd2147483648)
                return 32'sh8000_0000;
            return total[31:0];
        end
    endfunction

    // advance the predicted pose by one motion transaction
    function automatic pose_t integrate_motion(input motion_t m);
        longint fwd, lat, yaw, dt, cs, sn, dx, dy, dth;
        pose_t  p;
        begin
            fwd = longint'(m.forward_speed);
            lat = longint'(m.lateral_speed);
            yaw = longint'(m.yaw_rate);
            dt  = longint'(m.time_step);
            // rotation uses the heading from before this update
            heading_sincos(pose_heading, cs, sn);
            dx  = (fwd * cs - lat * sn) * dt;
            dy  = (fwd * sn + lat * cs) * dt;
            pose_x = clamp_add(pose_x, (dx + (64'sd1 <<< 41)) >>> 42);
            pose_y = clamp_add(pose_y, (dy + (64'sd1 <<< 41)) >>> 42);
            dth = (yaw * dt * ANGLE_TO_BAM + (64'sd1 <<< 43)) >>> 44;
            pose_heading = pose_heading + dth[15:0];
            p.pos_x   = pose_x;
            p.pos_y   = pose_y;
            p.heading = pose_heading;
            return p;
        end
    endfunction

    task automatic queue_motion(input logic [15:0] f, input logic [15:0] l,
                                input logic [15:0] y, input logic [15:0] d);
        motion_t m;
        begin
            m.forward_speed = f;
            m.lateral_speed = l;
            m.yaw_rate      = y;
            m.time_step     = d;
            pending_motion.push_back(m);
            motions_queued++;
        end
    endtask

    // waits until every queued transaction is taken and every result has come
    task automatic wait_drained();
        begin
            while (motions_taken != motions_queued || expected_pose.size() != 0)
                @(negedge clk);
            @(posedge clk);
        end
    endtask

    function automatic logic [15:0] extreme_value();
        begin
            case ($urandom_range(0, 5))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                4:       return 16'h0001;
                default: return 16'($urandom);
            endcase
        end
    endfunction

    // idling plan: sender sparse / receiver busy, then swapped, then neither idles
    function automatic int sender_gap_pct();
        return (motions_taken < 600) ? 21 : (motions_taken < 1200) ? 51 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (motions_taken < 600) ? 51 : (motions_taken < 1200) ? 21 : 0;
    endfunction

    // sender: offers the next pending motion, holds it until the transaction completes
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || motion_taken)
        begin
            motion_taken = 1'b0;
            if (pending_motion.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct())
            begin
                s_tdata  <= pending_motion.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (!hold_done && motions_taken >= HOLD_OFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
        end
    end

    // checks each result transaction, then predicts each accepted motion
    always @(posedge clk)
    begin : pose_checker
        pose_t got;
        pose_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_pose.size() == 0)
                begin
                    $error("result with no pose expected: %h", got);
                    fail_count++;
                end
                else
                begin
                    want = expected_pose.pop_front();
                    if (got.pos_x !== want.pos_x)
                    begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                        fail_count++;
                    end
                    if (got.pos_y !== want.pos_y)
                    begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                        fail_count++;
                    end
                    if (got.heading !== want.heading)
                    begin
                        $error("heading: expected %0d, got %0d", want.heading, got.heading);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_pose.push_back(integrate_motion(motion_t'(s_tdata)));
                motions_taken++;
                motion_taken = 1'b1;
            end
        end
    end

    initial
    begin
        int          start_count;
        int          seg_len;
        int          bam_need;
        int          yaw_fix;
        real         yaw_real;
        logic [15:0] base_f, base_l, base_y, dt_val;
        int          base_d;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed: field extremes, zero time step, heading wrap both ways, quadrants
        queue_motion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_motion(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF);
        queue_motion(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        queue_motion(16'h0000, 16'h8000, 16'h0000, 16'h0001);
        queue_motion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        queue_motion(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF);
        queue_motion(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        queue_motion(16'h0000, 16'h0000, 16'h8000, 16'hFFFF);
        queue_motion(16'h0000, 16'h0000, 16'h0001, 16'h0001);
        queue_motion(16'h1000, 16'h0000, 16'h0C91, 16'hFFFF);   // about an eighth turn
        queue_motion(16'h1000, 16'h0400, 16'h0C91, 16'hFFFF);
        repeat (4)
            queue_motion(16'h2000, 16'hE000, 16'h1922, 16'hFFFF);  // about a quarter turn
        queue_motion(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_motion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_motion(16'hFFFF, 16'h0001, 16'h8000, 16'h0001);
        queue_motion(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_motion(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        // sender pauses until every pose has come back
        wait_drained();

        // random: mostly smooth driving segments at a control-loop rate, plus noise
        start_count = motions_queued;
        while (motions_queued - start_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    queue_motion(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                2, 3, 4, 5, 6:
                begin
                    seg_len = $urandom_range(4, 30);
                    base_f  = $urandom_range(0, 1) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 8192) - 4096);
                    base_l  = 16'($urandom_range(0, 4096) - 2048);
                    base_y  = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                        : 16'($urandom_range(0, 2047) - 1024);
                    base_d  = $urandom_range(2000, 12000);
                    repeat (seg_len)
                    begin
                        dt_val = ($urandom_range(0, 19) == 0) ? 16'h0000
                                 : 16'(base_d + $urandom_range(0, 400) - 200);
                        queue_motion(base_f + 16'($urandom_range(0, 63)) - 16'd32,
                                     base_l + 16'($urandom_range(0, 63)) - 16'd32,
                                     base_y + 16'($urandom_range(0, 15)) - 16'd8,
                                     dt_val);
                    end
                end
                7:
                    queue_motion(16'($urandom), 16'($urandom), 16'($urandom), 16'h0000);
                8:
                    queue_motion(extreme_value(), extreme_value(), extreme_value(),
                                 extreme_value());
                default:
                    queue_motion(16'($urandom_range(0, 31) - 16),
                                 16'($urandom_range(0, 31) - 16),
                                 16'($urandom_range(0, 31) - 16),
                                 16'($urandom_range(0, 255)));
            endcase
        end
        wait_drained();

        // turn back to heading zero, then drive +x and -y flat out and reverse,
        // which gives the largest position steps back to back
        bam_need = (pose_heading >= 16'h8000) ? 65536 - int'(pose_heading)
                                              : -int'(pose_heading);
        yaw_real = bam_need * 17592186044416.0 / (65535.0 * 683565276.0);
        yaw_fix  = $rtoi(yaw_real + ((yaw_real >= 0.0) ? 0.5 : -0.5));
        queue_motion(16'h0000, 16'h0000, 16'(yaw_fix), 16'hFFFF);
        wait_drained();
        repeat (16)
            queue_motion(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        repeat (16)
            queue_motion(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        queue_motion(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));

        wait_drained();
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("PASS planar_odometry_integrator");
        else
            $display("FAIL planar_odometry_integrator");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial
    begin
        #40ms;
        $display("FAIL planar_odometry_integrator");
        $finish;
    end

endmodule
